/* src/jss_pkg.sv */
// Package for the Jacobi stencil sweep core: sizes, register indexes and the side clamp.
// It depends on nothing. The top level uses it through scoped names.
`default_nettype none

package jss_pkg;

  localparam int unsigned MaxSide  = 1024;
  localparam int unsigned CellBits = 16;
  localparam int unsigned ColBits  = $clog2(MaxSide);
  localparam int unsigned SideBits = $clog2(MaxSide + 1);
  localparam int unsigned CfgIdxBits = 1;

  typedef logic [CellBits-1:0] cell_t;
  typedef logic [ColBits-1:0]  col_t;
  typedef logic [SideBits-1:0] side_t;

  localparam logic [CfgIdxBits-1:0] CfgRowLength = 1'd0;
  localparam logic [CfgIdxBits-1:0] CfgRowCount  = 1'd1;

  localparam side_t MinSideVal = side_t'(3);
  localparam side_t MaxSideVal = side_t'(MaxSide);

  function automatic side_t clamp_side(input side_t v);
    side_t r;
    if (v < MinSideVal) begin
      r = MinSideVal;
    end else if (v > MaxSideVal) begin
      r = MaxSideVal;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/jss_ram.sv */
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// It depends on nothing. Contents are undefined until written.
`default_nettype none

module jss_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* src/jacobi_stencil_sweep_core.sv */
// Top level of the Jacobi five-point stencil sweep over a raster-ordered cell stream.
// It depends on jss_pkg and instantiates jss_ram for the row stores.
//
// Channel   Direction  Handshake                  Beat contents
// in        input      in_valid_i / in_ready_o    mode_i, cell_value_i
// out       output     out_valid_o / out_ready_i  new_value_o, is_border_o, last_cell_o
// cfg       input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// One beat is taken every cycle unless the output stalls; each beat that makes a result
// leaves it in the output register on the following cycle. The row stores are read at
// the next cell position as it is registered, so their read data is ready for the next beat.
// Reset sets length and count to maximum, clears positions and out_valid; stores need no clearing.
// A stalled output register stops input beats until the result is taken.
`default_nettype none

module jacobi_stencil_sweep_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [jss_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  wire logic [jss_pkg::SideBits-1:0]     cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             mode_i,
  input  wire logic [jss_pkg::CellBits-1:0]     cell_value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [jss_pkg::CellBits-1:0]     new_value_o,
  output logic                                  is_border_o,
  output logic                                  last_cell_o
);

  localparam int unsigned SumBits = jss_pkg::CellBits + 2;

  jss_pkg::side_t len_q, len_d, cnt_q, cnt_d;
  jss_pkg::col_t  len_last_q, len_last_d;
  jss_pkg::col_t  col_q, col_d;
  jss_pkg::side_t row_q, row_d;
  jss_pkg::cell_t west_q, west_d;

  logic           out_valid_q, out_valid_d;
  jss_pkg::cell_t new_value_q, new_value_d;
  logic           is_border_q, is_border_d;
  logic           last_cell_q, last_cell_d;

  logic [2*jss_pkg::CellBits-1:0] pair_rdata;
  jss_pkg::cell_t                 east_rdata;
  jss_pkg::cell_t                 centre, north;
  jss_pkg::side_t                 cfg_side;
  logic [SumBits-1:0]             sum;

  logic accept, flush, sample, produce, border, col_last, ram_we;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign centre = pair_rdata[jss_pkg::CellBits-1:0];
  assign north  = pair_rdata[2*jss_pkg::CellBits-1:jss_pkg::CellBits];

  assign flush    = (row_q == cnt_q);
  assign sample   = !flush && !mode_i;
  assign produce  = flush || (sample && (row_q != '0));
  assign col_last = (col_q == len_last_q);
  assign border   = flush || (row_q == jss_pkg::side_t'(1)) || (col_q == '0) || col_last;
  assign ram_we   = accept && sample;
  assign cfg_side = jss_pkg::clamp_side(cfg_data_i);

  assign sum = {2'b00, north} + {2'b00, cell_value_i} + {2'b00, west_q} + {2'b00, east_rdata};

  always_comb begin
    len_d       = len_q;
    cnt_d       = cnt_q;
    len_last_d  = len_last_q;
    col_d       = col_q;
    row_d       = row_q;
    west_d      = west_q;
    out_valid_d = out_valid_q && !out_ready_i;
    new_value_d = new_value_q;
    is_border_d = is_border_q;
    last_cell_d = last_cell_q;

    if (cfg_we_i) begin
      case (cfg_index_i)
        jss_pkg::CfgRowLength: begin
          len_d      = cfg_side;
          len_last_d = jss_pkg::col_t'(cfg_side - jss_pkg::side_t'(1));
        end
        jss_pkg::CfgRowCount: begin
          cnt_d = cfg_side;
        end
        default: begin
        end
      endcase
      col_d  = '0;
      row_d  = '0;
      west_d = '0;
    end else if (accept) begin
      if (produce) begin
        out_valid_d = 1'b1;
        new_value_d = border ? centre : sum[SumBits-1:2];
        is_border_d = border;
        last_cell_d = flush && col_last;
      end
      if (flush) begin
        if (col_last) begin
          col_d  = '0;
          row_d  = '0;
          west_d = '0;
        end else begin
          col_d = col_q + jss_pkg::col_t'(1);
        end
      end else if (sample) begin
        west_d = centre;
        if (col_last) begin
          col_d = '0;
          row_d = row_q + jss_pkg::side_t'(1);
        end else begin
          col_d = col_q + jss_pkg::col_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= jss_pkg::MaxSideVal;
      cnt_q       <= jss_pkg::MaxSideVal;
      len_last_q  <= jss_pkg::col_t'(jss_pkg::MaxSide - 1);
      col_q       <= '0;
      row_q       <= '0;
      west_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      len_last_q  <= len_last_d;
      col_q       <= col_d;
      row_q       <= row_d;
      west_q      <= west_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_value_q <= new_value_d;
    is_border_q <= is_border_d;
    last_cell_q <= last_cell_d;
  end

  // The upper and middle rows share one address, so they sit side by side in one RAM.
  jss_ram #(
    .Width (2 * jss_pkg::CellBits),
    .Depth (jss_pkg::MaxSide)
  ) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_q),
    .wdata_i ({centre, cell_value_i}),
    .raddr_i (col_d),
    .rdata_o (pair_rdata)
  );

  // A copy of the middle row, read one cell further on for the east neighbour.
  jss_ram #(
    .Width (jss_pkg::CellBits),
    .Depth (jss_pkg::MaxSide)
  ) u_east_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_q),
    .wdata_i (cell_value_i),
    .raddr_i (col_d + jss_pkg::col_t'(1)),
    .rdata_o (east_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign new_value_o = new_value_q;
  assign is_border_o = is_border_q;
  assign last_cell_o = last_cell_q;

`ifndef ASSERT_OFF
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, col_q} < len_q)
    else $error("column position beyond row length");

  a_row_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= cnt_q)
    else $error("row position beyond row count");

  a_last_is_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_cell_o |-> is_border_o)
    else $error("final cell not marked as border");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && produce && !cfg_we_i |=> out_valid_q)
    else $error("result of an accepted beat was lost");
`endif

endmodule

`default_nettype wire
